// ===== hdl/dd_pkg.sv =====
// Shared widths, types and the month offset table for the date difference block.
`default_nettype none
package dd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 23;

    // biased year: year + 400 less one for Jan/Feb, below 2^15
    localparam int YB_W    = YEAR_W + 1;
    // month offset plus day - 1, at most 367
    localparam int MO_W    = 9;
    // quotient by 100 of the biased year, at most 167
    localparam int Q100_W  = 8;
    // day number, below 2^23
    localparam int DN_W    = 23;

    localparam logic [YB_W-1:0] YEAR_BIAS = YB_W'(400);
    // yy / 100 == (yy * 5243) >> 19 for all yy below 2^15
    localparam int              RECIP_100_SHIFT = 19;
    localparam logic [12:0]     RECIP_100 = 13'd5243;
    localparam int              PROD_W = YB_W + 13;
    localparam logic [8:0]      DAYS_PER_YEAR = 9'd365;

    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_MAX   = DAY_W'(31);

    localparam logic signed [COUNT_W:0] COUNT_MAX = (COUNT_W+1)'(4194303);
    localparam logic signed [COUNT_W:0] COUNT_MIN = -(COUNT_W+1)'(4194304);

    // days from 1 March to the first of the month, months counted from March
    function automatic logic [MO_W-1:0] month_offset(input logic [MONTH_W-1:0] mp);
        logic [MO_W-1:0] r;
        begin
            case (mp)
                4'd0:    r = 9'd0;
                4'd1:    r = 9'd31;
                4'd2:    r = 9'd61;
                4'd3:    r = 9'd92;
                4'd4:    r = 9'd122;
                4'd5:    r = 9'd153;
                4'd6:    r = 9'd184;
                4'd7:    r = 9'd214;
                4'd8:    r = 9'd245;
                4'd9:    r = 9'd275;
                4'd10:   r = 9'd306;
                4'd11:   r = 9'd337;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic [YB_W-1:0] yy;
        logic [MO_W-1:0] mo;
    } date_s1_t;

    typedef struct packed {
        logic [DN_W-1:0]   y365;
        logic [YB_W-3:0]   y4;
        logic [Q100_W-1:0] q100;
        logic [MO_W-1:0]   mo;
    } date_s2_t;

endpackage
`default_nettype wire

// ===== hdl/date_difference_days.sv =====
// Top level: pipelined signed day count between two Gregorian dates.
//
// Usage: drive both dates on the first_* and second_* ports and pulse start.
// An item is taken at every clock edge where start is high and busy is low;
// busy is always low, so a new item may be given in every cycle.
// Each item gives one result: day_count (second minus first, signed, in
// days) and bad_date, shown for one cycle with done high. A date with its
// month outside 1..12 or its day outside 1..31 sets bad_date and gives a
// count of 0. A day past the month end runs on into the next month.
// Throughput is one item per cycle. The path has four register stages:
// month decode, the multiplies by 365 and by the reciprocal of 100, the
// day number sum, and the subtract with saturation.
// The receiver cannot stall, so nothing is held back and no result waits.
// Reset clears all valid bits; items in flight are dropped and done is low.
`default_nettype none
module date_difference_days (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dd_pkg::DAY_W-1:0]      first_day,
    input  wire logic [dd_pkg::MONTH_W-1:0]    first_month,
    input  wire logic [dd_pkg::YEAR_W-1:0]     first_year,
    input  wire logic [dd_pkg::DAY_W-1:0]      second_day,
    input  wire logic [dd_pkg::MONTH_W-1:0]    second_month,
    input  wire logic [dd_pkg::YEAR_W-1:0]     second_year,
    output logic                               done,
    output logic signed [dd_pkg::COUNT_W-1:0]  day_count,
    output logic                               bad_date
);

    logic                       accept;
    logic [dd_pkg::DAY_W-1:0]   day_in   [0:1];
    logic [dd_pkg::MONTH_W-1:0] month_in [0:1];
    logic [dd_pkg::YEAR_W-1:0]  year_in  [0:1];

    logic v1_reg, v2_reg, v3_reg;
    logic bad1_reg, bad2_reg, bad3_reg;
    dd_pkg::date_s1_t s1_reg [0:1];
    dd_pkg::date_s1_t s1_next [0:1];
    dd_pkg::date_s2_t s2_reg [0:1];
    dd_pkg::date_s2_t s2_next [0:1];
    logic [dd_pkg::DN_W-1:0] dn_reg [0:1];
    logic [dd_pkg::DN_W-1:0] dn_next [0:1];
    logic bad_next;

    logic signed [dd_pkg::COUNT_W:0]   diff;
    logic signed [dd_pkg::COUNT_W-1:0] count_next;

    logic done_reg;
    logic signed [dd_pkg::COUNT_W-1:0] count_reg;
    logic bad_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign day_in[0]   = first_day;
    assign day_in[1]   = second_day;
    assign month_in[0] = first_month;
    assign month_in[1] = second_month;
    assign year_in[0]  = first_year;
    assign year_in[1]  = second_year;

    // stage 1: range check, March-based month, biased year
    always_comb
    begin
        bad_next = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            logic [dd_pkg::MONTH_W-1:0] mp;
            logic [dd_pkg::YB_W-1:0]    yy;
            yy = {1'b0, year_in[i]} + dd_pkg::YEAR_BIAS;
            if (month_in[i] <= dd_pkg::MONTH_FEB)
            begin
                yy = yy - dd_pkg::YB_W'(1);
                mp = month_in[i] + dd_pkg::MONTH_W'(9);
            end
            else
            begin
                mp = month_in[i] - dd_pkg::MONTH_W'(3);
            end
            s1_next[i].yy = yy;
            s1_next[i].mo = dd_pkg::month_offset(mp)
                          + dd_pkg::MO_W'(day_in[i]) - dd_pkg::MO_W'(1);
            if (month_in[i] == '0 || month_in[i] > dd_pkg::MONTH_DEC
                || day_in[i] == '0 || day_in[i] > dd_pkg::DAY_MAX)
            begin
                bad_next = 1'b1;
            end
        end
    end

    // stage 2: year multiplies
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            logic [dd_pkg::PROD_W-1:0] prod;
            prod = dd_pkg::PROD_W'(s1_reg[i].yy) * dd_pkg::PROD_W'(dd_pkg::RECIP_100);
            s2_next[i].y365 = dd_pkg::DN_W'(s1_reg[i].yy) * dd_pkg::DN_W'(dd_pkg::DAYS_PER_YEAR);
            s2_next[i].y4   = s1_reg[i].yy[dd_pkg::YB_W-1:2];
            s2_next[i].q100 = prod[dd_pkg::RECIP_100_SHIFT +: dd_pkg::Q100_W];
            s2_next[i].mo   = s1_reg[i].mo;
        end
    end

    // stage 3: day numbers; yy/400 taken as (yy/100)/4
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            dn_next[i] = s2_reg[i].y365 + dd_pkg::DN_W'(s2_reg[i].y4)
                       - dd_pkg::DN_W'(s2_reg[i].q100)
                       + dd_pkg::DN_W'(s2_reg[i].q100[dd_pkg::Q100_W-1:2])
                       + dd_pkg::DN_W'(s2_reg[i].mo);
        end
    end

    // stage 4: difference, saturation, invalid override
    always_comb
    begin
        diff = $signed({1'b0, dn_reg[1]}) - $signed({1'b0, dn_reg[0]});
        if (bad3_reg)
            count_next = '0;
        else if (diff > dd_pkg::COUNT_MAX)
            count_next = dd_pkg::COUNT_MAX[dd_pkg::COUNT_W-1:0];
        else if (diff < dd_pkg::COUNT_MIN)
            count_next = dd_pkg::COUNT_MIN[dd_pkg::COUNT_W-1:0];
        else
            count_next = diff[dd_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        dn_reg    <= dn_next;
        bad1_reg  <= bad_next;
        bad2_reg  <= bad1_reg;
        bad3_reg  <= bad2_reg;
        count_reg <= count_next;
        bad_reg   <= bad3_reg;
    end

    assign done      = done_reg;
    assign day_count = count_reg;
    assign bad_date  = bad_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without an item four cycles earlier");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_date) |-> (day_count == '0))
        else $error("invalid date gave a non-zero count");

    a_same_date: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_day == second_day && first_month == second_month
         && first_year == second_year) |-> ##4 (done && day_count == '0))
        else $error("equal dates gave a non-zero count");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule
`default_nettype wire
